### hdl/buar_pkg.sv
`timescale 1ns / 1ps
// shared types and constants of the batched upload ack receiver
package buar_pkg;

  localparam int POS_W      = 32;
  localparam int LEN_W      = 16;
  localparam int BATCH_W    = 11;
  localparam int TMO_W      = 16;
  localparam int RETRY_W    = 8;
  localparam int CNT_W      = 32;
  localparam int IN_DATA_W  = 80;
  localparam int OUT_DATA_W = 40;
  localparam int ADDR_W     = 5;
  localparam int FIFO_DEPTH = 4;
  localparam int PTR_W      = $clog2(FIFO_DEPTH);
  localparam int FILL_W     = $clog2(FIFO_DEPTH + 1);

  localparam logic [CNT_W-1:0] MIN_BLOCKS_FOR_FAST = 32'd2;

  localparam logic [BATCH_W-1:0] BATCH_ACK_SIZE_RST     = 11'd40;
  localparam logic [TMO_W-1:0]   FIRST_TIMEOUT_RST      = 16'd5000;
  localparam logic [TMO_W-1:0]   BLOCK_TIMEOUT_RST      = 16'd1000;
  localparam logic [RETRY_W-1:0] MAX_RETRIES_RST        = 8'd5;
  localparam logic [CNT_W-1:0]   OVERALL_TIMEOUT_RST    = 32'd600000;

  typedef enum logic [2:0] {
    FUNC_START  = 3'd0,
    FUNC_BLOCK  = 3'd1,
    FUNC_TICK   = 3'd2,
    FUNC_END    = 3'd3,
    FUNC_CANCEL = 3'd4
  } func_t;

  typedef enum logic [2:0] {
    RES_START_OK  = 3'd0,
    RES_START_REJ = 3'd1,
    RES_VERDICT   = 3'd2,
    RES_TMO_ACK   = 3'd3,
    RES_CANCELLED = 3'd4,
    RES_ENDED     = 3'd5
  } kind_t;

  typedef enum logic [1:0] {
    RSN_UNEXPECTED = 2'd0,
    RSN_RETRIES    = 2'd1,
    RSN_OVERALL    = 2'd2,
    RSN_HOST       = 2'd3
  } reason_t;

  typedef enum logic [2:0] {
    REG_BATCH_ACK_SIZE  = 3'd0,
    REG_FIRST_TIMEOUT   = 3'd1,
    REG_BLOCK_TIMEOUT   = 3'd2,
    REG_MAX_RETRIES     = 3'd3,
    REG_OVERALL_TIMEOUT = 3'd4
  } reg_t;

  typedef struct packed {
    kind_t            kind;
    logic [POS_W-1:0] okto;
    logic             valid;
    logic             first;
    logic             fin;
    logic             ack;
    reason_t          reason;
    logic             last;
  } res_t;

endpackage

### hdl/batched_upload_ack_receiver.sv
`timescale 1ns / 1ps
// top level: upload event processing, config registers and result queue
//
// events enter on the s_ channel (kind in s_tuser, position, length and size
// in s_tdata); results leave on the m_ channel (kind in m_tuser, okto and
// flags in m_tdata, m_tlast on the last result of an event).
// each event is evaluated in the cycle it is accepted and its zero, one or
// two results are written into a four-entry result queue; the first result
// is registered there and reaches m_ once the results ahead of it are taken.
// throughput is one event per clock while the queue has room for two
// results: s_tready drops once three results are queued, so an event that
// yields two results, or a stalled m_tready, costs input cycles until the
// queue drains. the queue read port sets the output rate of one result per
// clock while m_tready is high.
// the apb port holds five timeout, retry and batch registers, written and
// read at byte address 4*index; pready is always high.
// rst clears the upload state, restores register defaults and empties the
// queue.
module batched_upload_ack_receiver (
  input  logic                               clk,
  input  logic                               rst,
  // event channel
  input  logic                               s_tvalid,
  output logic                               s_tready,
  input  logic [buar_pkg::IN_DATA_W-1:0]     s_tdata,  // file_pos, block_len, file_size
  input  logic [2:0]                         s_tuser,  // func
  // result channel
  output logic                               m_tvalid,
  input  logic                               m_tready,
  // okto, block_valid, first_block, final_block, ack, cancel_reason, zero pad
  output logic [buar_pkg::OUT_DATA_W-1:0]    m_tdata,
  output logic [2:0]                         m_tuser,  // result_kind
  output logic                               m_tlast,
  // config port
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [buar_pkg::ADDR_W-1:0]        paddr,
  input  logic [31:0]                        pwdata,
  output logic [31:0]                        prdata,
  output logic                               pready
);

  // config registers
  logic [buar_pkg::BATCH_W-1:0] batch_ack_size;
  logic [buar_pkg::TMO_W-1:0]   first_timeout_ms;
  logic [buar_pkg::TMO_W-1:0]   block_timeout_ms;
  logic [buar_pkg::RETRY_W-1:0] max_retries;
  logic [buar_pkg::CNT_W-1:0]   overall_timeout_ms;

  // upload state
  logic                         uploading, uploading_next;
  logic [buar_pkg::POS_W-1:0]   expected_pos, expected_pos_next;
  logic [buar_pkg::POS_W-1:0]   file_length, file_length_next;
  logic [buar_pkg::CNT_W-1:0]   valid_blocks, valid_blocks_next;
  logic [buar_pkg::BATCH_W-1:0] batch_count, batch_count_next;
  logic [buar_pkg::RETRY_W-1:0] retry_count, retry_count_next;
  logic [buar_pkg::CNT_W-1:0]   idle_ms, idle_ms_next;
  logic [buar_pkg::CNT_W-1:0]   elapsed_ms, elapsed_ms_next;

  // result queue
  buar_pkg::res_t               fifo_mem [buar_pkg::FIFO_DEPTH];
  logic [buar_pkg::PTR_W-1:0]   wr_ptr;
  logic [buar_pkg::PTR_W-1:0]   rd_ptr;
  logic [buar_pkg::FILL_W-1:0]  fill;

  // event fields
  buar_pkg::func_t              func;
  logic [buar_pkg::POS_W-1:0]   file_pos;
  logic [buar_pkg::LEN_W-1:0]   block_len;
  logic [buar_pkg::POS_W-1:0]   file_size;

  logic                         accept;
  logic                         pop;
  logic                         cfg_wr;
  buar_pkg::reg_t               reg_sel;

  buar_pkg::res_t               res0, res1;
  logic [1:0]                   res_n;
  logic [1:0]                   push_n;

  logic [buar_pkg::CNT_W-1:0]   idle_inc, elapsed_inc, blocks_inc;
  logic [buar_pkg::RETRY_W-1:0] retry_inc;
  logic [buar_pkg::BATCH_W-1:0] batch_inc;
  logic [buar_pkg::TMO_W-1:0]   idle_limit;
  logic [buar_pkg::POS_W:0]     block_end;
  logic                         idle_fire, retry_ok, overall_fire;

  assign func      = buar_pkg::func_t'(s_tuser);
  assign file_pos  = s_tdata[31:0];
  assign block_len = s_tdata[47:32];
  assign file_size = s_tdata[79:48];

  // room for the two results an event can produce
  assign s_tready = (fill <= buar_pkg::FILL_W'(buar_pkg::FIFO_DEPTH - 2));
  assign accept   = s_tvalid && s_tready;
  assign m_tvalid = (fill != '0);
  assign pop      = m_tvalid && m_tready;

  assign m_tuser = fifo_mem[rd_ptr].kind;
  assign m_tlast = fifo_mem[rd_ptr].last;
  assign m_tdata = {2'b00, fifo_mem[rd_ptr].reason, fifo_mem[rd_ptr].ack,
                    fifo_mem[rd_ptr].fin, fifo_mem[rd_ptr].first,
                    fifo_mem[rd_ptr].valid, fifo_mem[rd_ptr].okto};

  // config port
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign reg_sel = buar_pkg::reg_t'(paddr[4:2]);

  always_comb begin
    case (reg_sel)
      buar_pkg::REG_BATCH_ACK_SIZE:  prdata = {21'b0, batch_ack_size};
      buar_pkg::REG_FIRST_TIMEOUT:   prdata = {16'b0, first_timeout_ms};
      buar_pkg::REG_BLOCK_TIMEOUT:   prdata = {16'b0, block_timeout_ms};
      buar_pkg::REG_MAX_RETRIES:     prdata = {24'b0, max_retries};
      buar_pkg::REG_OVERALL_TIMEOUT: prdata = overall_timeout_ms;
      default:                       prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      batch_ack_size     <= buar_pkg::BATCH_ACK_SIZE_RST;
      first_timeout_ms   <= buar_pkg::FIRST_TIMEOUT_RST;
      block_timeout_ms   <= buar_pkg::BLOCK_TIMEOUT_RST;
      max_retries        <= buar_pkg::MAX_RETRIES_RST;
      overall_timeout_ms <= buar_pkg::OVERALL_TIMEOUT_RST;
    end else if (cfg_wr) begin
      case (reg_sel)
        buar_pkg::REG_BATCH_ACK_SIZE:  batch_ack_size     <= pwdata[10:0];
        buar_pkg::REG_FIRST_TIMEOUT:   first_timeout_ms   <= pwdata[15:0];
        buar_pkg::REG_BLOCK_TIMEOUT:   block_timeout_ms   <= pwdata[15:0];
        buar_pkg::REG_MAX_RETRIES:     max_retries        <= pwdata[7:0];
        buar_pkg::REG_OVERALL_TIMEOUT: overall_timeout_ms <= pwdata;
        default: ;
      endcase
    end
  end

  // counter steps; all but the batch step saturate
  assign idle_inc    = (idle_ms == '1) ? idle_ms : idle_ms + 32'd1;
  assign elapsed_inc = (elapsed_ms == '1) ? elapsed_ms : elapsed_ms + 32'd1;
  assign blocks_inc  = (valid_blocks == '1) ? valid_blocks : valid_blocks + 32'd1;
  assign retry_inc   = (retry_count == '1) ? retry_count : retry_count + 8'd1;
  assign batch_inc   = batch_count + 11'd1;

  assign idle_limit   = (valid_blocks < buar_pkg::MIN_BLOCKS_FOR_FAST) ?
                        first_timeout_ms : block_timeout_ms;
  assign idle_fire    = (idle_inc > {16'b0, idle_limit});
  assign retry_ok     = (retry_inc < max_retries);
  assign overall_fire = (elapsed_inc > overall_timeout_ms);
  // end of block without wrap for the final test
  assign block_end    = {1'b0, file_pos} + {17'b0, block_len};

  always_comb begin
    uploading_next    = uploading;
    expected_pos_next = expected_pos;
    file_length_next  = file_length;
    valid_blocks_next = valid_blocks;
    batch_count_next  = batch_count;
    retry_count_next  = retry_count;
    idle_ms_next      = idle_ms;
    elapsed_ms_next   = elapsed_ms;
    res0              = '0;
    res1              = '0;
    res_n             = 2'd0;

    case (func)
      buar_pkg::FUNC_START: begin
        res_n = 2'd1;
        if (uploading && expected_pos != '0) begin
          res0.kind = buar_pkg::RES_START_REJ;
          res0.okto = expected_pos;
        end else begin
          uploading_next    = 1'b1;
          file_length_next  = file_size;
          expected_pos_next = '0;
          valid_blocks_next = '0;
          batch_count_next  = '0;
          retry_count_next  = '0;
          idle_ms_next      = '0;
          elapsed_ms_next   = '0;
          res0.kind         = buar_pkg::RES_START_OK;
        end
      end
      buar_pkg::FUNC_BLOCK: begin
        res_n = 2'd1;
        if (!uploading) begin
          res0.kind   = buar_pkg::RES_CANCELLED;
          res0.okto   = expected_pos;
          res0.reason = buar_pkg::RSN_UNEXPECTED;
        end else begin
          idle_ms_next     = '0;
          retry_count_next = '0;
          if (file_pos == expected_pos) begin
            res0.valid        = 1'b1;
            expected_pos_next = expected_pos + {16'b0, block_len};
            valid_blocks_next = blocks_inc;
            res0.first        = (file_pos == '0);
            res0.fin          = (block_end >= {1'b0, file_length});
          end
          res0.ack = (batch_inc == batch_ack_size) || (valid_blocks_next == 32'd1) ||
                     res0.fin;
          batch_count_next = res0.ack ? '0 : batch_inc;
          res0.kind        = buar_pkg::RES_VERDICT;
          res0.okto        = expected_pos_next;
        end
      end
      buar_pkg::FUNC_TICK: begin
        if (uploading) begin
          idle_ms_next    = idle_inc;
          elapsed_ms_next = elapsed_inc;
          if (idle_fire) begin
            retry_count_next = retry_inc;
          end
          res0.okto = expected_pos;
          res1.okto = expected_pos;
          if (idle_fire && retry_ok) begin
            // retry: ack again and skip the overall check
            idle_ms_next = '0;
            res0.kind    = buar_pkg::RES_TMO_ACK;
            res0.ack     = 1'b1;
            res_n        = 2'd1;
          end else begin
            if (idle_fire) begin
              uploading_next = 1'b0;
              res0.kind      = buar_pkg::RES_CANCELLED;
              res0.reason    = buar_pkg::RSN_RETRIES;
            end
            if (overall_fire) begin
              uploading_next = 1'b0;
              if (idle_fire) begin
                res1.kind   = buar_pkg::RES_CANCELLED;
                res1.reason = buar_pkg::RSN_OVERALL;
              end else begin
                res0.kind   = buar_pkg::RES_CANCELLED;
                res0.reason = buar_pkg::RSN_OVERALL;
              end
            end
            res_n = {1'b0, idle_fire} + {1'b0, overall_fire};
          end
        end
      end
      buar_pkg::FUNC_END: begin
        uploading_next = 1'b0;
        res0.kind      = buar_pkg::RES_ENDED;
        res0.okto      = expected_pos;
        res_n          = 2'd1;
      end
      buar_pkg::FUNC_CANCEL: begin
        uploading_next = 1'b0;
        res0.kind      = buar_pkg::RES_CANCELLED;
        res0.okto      = expected_pos;
        res0.reason    = buar_pkg::RSN_HOST;
        res_n          = 2'd1;
      end
      default: ;
    endcase

    res0.last = (res_n == 2'd1);
    res1.last = (res_n == 2'd2);
  end

  assign push_n = accept ? res_n : 2'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      uploading    <= 1'b0;
      expected_pos <= '0;
      file_length  <= '0;
      valid_blocks <= '0;
      batch_count  <= '0;
      retry_count  <= '0;
      idle_ms      <= '0;
      elapsed_ms   <= '0;
    end else if (accept) begin
      uploading    <= uploading_next;
      expected_pos <= expected_pos_next;
      file_length  <= file_length_next;
      valid_blocks <= valid_blocks_next;
      batch_count  <= batch_count_next;
      retry_count  <= retry_count_next;
      idle_ms      <= idle_ms_next;
      elapsed_ms   <= elapsed_ms_next;
    end
  end

  always_ff @(posedge clk) begin
    if (push_n != 2'd0) begin
      fifo_mem[wr_ptr] <= res0;
    end
    if (push_n == 2'd2) begin
      fifo_mem[wr_ptr + buar_pkg::PTR_W'(1)] <= res1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      wr_ptr <= wr_ptr + buar_pkg::PTR_W'(push_n);
      if (pop) begin
        rd_ptr <= rd_ptr + buar_pkg::PTR_W'(1);
      end
      fill <= fill + buar_pkg::FILL_W'(push_n) - buar_pkg::FILL_W'(pop);
    end
  end

endmodule

### hdl/buar_checker.sv
`timescale 1ns / 1ps
// port-level checker for the batched upload ack receiver, with its bind
module buar_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            s_tvalid,
  input logic                            s_tready,
  input logic [2:0]                      s_tuser,
  input logic                            m_tvalid,
  input logic                            m_tready,
  input logic [buar_pkg::OUT_DATA_W-1:0] m_tdata,
  input logic [2:0]                      m_tuser,
  input logic                            m_tlast
);

  // queue is empty right after reset
  a_empty_after_rst: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result pending right after reset");

  // an end or cancel transaction always leaves a result behind
  a_end_answered: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready && (s_tuser == buar_pkg::FUNC_END ||
                              s_tuser == buar_pkg::FUNC_CANCEL)) |=> m_tvalid)
    else $error("end or cancel transaction produced no result");

  // a timeout ack is a single result that requests an ack
  a_tmo_ack_form: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser == buar_pkg::RES_TMO_ACK) |-> (m_tlast && m_tdata[35]))
    else $error("timeout ack without ack flag or last");

  // verdict flags stay zero outside block verdicts
  a_flags_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser != buar_pkg::RES_VERDICT) |-> (m_tdata[34:32] == 3'b000))
    else $error("block flags set on a non-verdict result");

  // stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)))
    else $error("stalled result changed");

endmodule

bind batched_upload_ack_receiver buar_checker u_buar_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .s_tuser  (s_tuser),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser),
  .m_tlast  (m_tlast)
);
